>>> rtl/kfss_pkg.sv
// ----------------------------------------------------------------------------
// kfss_pkg: shared types and constants of the keypad floor stepper
// Holds the item and result structs, the key codes and the seven-segment
// encoding used by the control core and the display decoder.
// ----------------------------------------------------------------------------
package kfss_pkg;

  localparam int unsigned FloorW  = 14;
  localparam int unsigned DigitsW = 3;
  localparam int unsigned NumDig  = 4;

  // Item kinds carried in the mode field.
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // ASCII key codes that mean something.
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;
  localparam logic [7:0] KEY_CLEAR = 8'h2A;
  localparam logic [7:0] KEY_GO    = 8'h73;

  localparam logic [DigitsW-1:0] DIGIT_LIMIT = 3'd4;
  localparam logic [FloorW-1:0]  FLOOR_RESET = 14'd1;

  typedef logic [FloorW-1:0] floor_t;
  // Four BCD digits, index 0 is the ones digit.
  typedef logic [NumDig-1:0][3:0] bcd_t;
  typedef logic [NumDig-1:0][7:0] seg_vec_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_code;
  } kfss_in_t;

  typedef struct packed {
    logic [13:0] floor_now;
    logic [13:0] entry_value;
    logic [7:0]  seg_ones;
    logic [7:0]  seg_tens;
    logic [7:0]  seg_hundreds;
    logic [7:0]  seg_thousands;
    logic        moving;
    logic        going_up;
    logic        arrived;
    logic        rejected;
  } kfss_out_t;

  // State after one item, as seen by the result stage.
  typedef struct packed {
    floor_t floor;
    bcd_t   floor_bcd;
    floor_t entry;
    logic   moving;
    logic   going_up;
    logic   arrived;
    logic   rejected;
  } kfss_view_t;

  // Segment pattern of one decimal digit, bit0 = A .. bit6 = G, DP off.
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h27;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h67;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> rtl/kfss_ctrl.sv
// ----------------------------------------------------------------------------
// kfss_ctrl: keypad entry and floor travel state
// Keeps the entry accumulator, target, travel flags and the current floor
// in binary and in BCD, and gives the state that follows the present item.
// ----------------------------------------------------------------------------
module kfss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  kfss_pkg::kfss_in_t  item_i,
  output kfss_pkg::kfss_view_t view_o
);
  import kfss_pkg::*;

  floor_t             cur_q, cur_d;
  bcd_t               bcd_q, bcd_d;
  floor_t             tgt_q, tgt_d;
  floor_t             acc_q, acc_d;
  logic [DigitsW-1:0] ndig_q, ndig_d;
  logic               active_q, active_d;
  logic               up_q, up_d;
  logic               arrived, rejected;
  logic               step_up, carry;
  floor_t             acc_x10;

  assign acc_x10 = (acc_q << 3) + (acc_q << 1);
  assign step_up = cur_q < tgt_q;

  always_comb begin
    cur_d    = cur_q;
    bcd_d    = bcd_q;
    tgt_d    = tgt_q;
    acc_d    = acc_q;
    ndig_d   = ndig_q;
    active_d = active_q;
    up_d     = up_q;
    arrived  = 1'b0;
    rejected = 1'b0;
    carry    = 1'b1;
    if (item_i.mode == MODE_KEY) begin
      if (!active_q) begin
        if (item_i.key_code inside {[KEY_ZERO:KEY_NINE]}) begin
          if (ndig_q < DIGIT_LIMIT) begin
            acc_d  = acc_x10 + floor_t'(item_i.key_code - KEY_ZERO);
            ndig_d = ndig_q + 1'b1;
          end
        end else if (item_i.key_code == KEY_CLEAR) begin
          acc_d  = '0;
          ndig_d = '0;
        end else if (item_i.key_code == KEY_GO) begin
          tgt_d  = acc_q;
          acc_d  = '0;
          ndig_d = '0;
          if (acc_q == cur_q) begin
            rejected = 1'b1;
          end else begin
            active_d = 1'b1;
            up_d     = acc_q > cur_q;
          end
        end
      end
    end else if (active_q) begin
      // While travelling the floor never equals the target, so one step
      // is always taken. The BCD copy ripples a carry or borrow.
      cur_d = step_up ? cur_q + 1'b1 : cur_q - 1'b1;
      for (int i = 0; i < NumDig; i++) begin
        if (carry) begin
          if (step_up) begin
            if (bcd_q[i] == 4'd9) begin
              bcd_d[i] = 4'd0;
            end else begin
              bcd_d[i] = bcd_q[i] + 4'd1;
              carry    = 1'b0;
            end
          end else begin
            if (bcd_q[i] == 4'd0) begin
              bcd_d[i] = 4'd9;
            end else begin
              bcd_d[i] = bcd_q[i] - 4'd1;
              carry    = 1'b0;
            end
          end
        end
      end
      if (cur_d == tgt_q) begin
        active_d = 1'b0;
        arrived  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= FLOOR_RESET;
      bcd_q    <= bcd_t'(1);
      tgt_q    <= '0;
      acc_q    <= '0;
      ndig_q   <= '0;
      active_q <= 1'b0;
      up_q     <= 1'b0;
    end else if (accept_i) begin
      cur_q    <= cur_d;
      bcd_q    <= bcd_d;
      tgt_q    <= tgt_d;
      acc_q    <= acc_d;
      ndig_q   <= ndig_d;
      active_q <= active_d;
      up_q     <= up_d;
    end
  end

  assign view_o.floor     = cur_d;
  assign view_o.floor_bcd = bcd_d;
  assign view_o.entry     = acc_d;
  assign view_o.moving    = active_d;
  assign view_o.going_up  = active_d & up_d;
  assign view_o.arrived   = arrived;
  assign view_o.rejected  = rejected;

`ifndef SYNTHESIS
  a_travel_not_there: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cur_q != tgt_q))
    else $error("travel active while already at target");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= DIGIT_LIMIT)
    else $error("entry digit count above limit");

  a_empty_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ndig_q == '0) |-> (acc_q == '0))
    else $error("entry value set with no digits");

  a_bcd_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(bcd_q[3]) * 32'd1000 + 32'(bcd_q[2]) * 32'd100
     + 32'(bcd_q[1]) * 32'd10 + 32'(bcd_q[0])) == 32'(cur_q))
    else $error("BCD floor copy out of step with binary floor");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !(arrived && rejected))
    else $error("arrived and rejected on the same item");
`endif

endmodule

>>> rtl/kfss_seg_dec.sv
// ----------------------------------------------------------------------------
// kfss_seg_dec: four-digit seven-segment decoder
// Turns the BCD floor digits into segment patterns, one table per digit.
// ----------------------------------------------------------------------------
module kfss_seg_dec (
  input  kfss_pkg::bcd_t     bcd_i,
  output kfss_pkg::seg_vec_t seg_o
);
  import kfss_pkg::*;

  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      seg_o[i] = seg_of(bcd_i[i]);
    end
  end

endmodule

>>> rtl/keypad_floor_stepper_seven_segment.sv
// ----------------------------------------------------------------------------
// keypad_floor_stepper_seven_segment: keypad-driven floor stepper
// Collects a floor number from keypad digits, travels one floor per tick
// toward it and shows the current floor on four seven-segment digits.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | input     | in_valid_i / in_stall_o | kfss_in_t  (mode, key_code)
//  out      | output    | out_valid_o/ out_stall_i| kfss_out_t (floor, segments,
//           |           |                         |   entry, motion flags)
//
// Every input transaction yields exactly one output transaction, in the cycle
// after it is accepted. One transaction can be accepted in every cycle.
// The throughput is set by the single result register: the input stalls
// only while that register holds a result and the output side stalls.
// After reset the current floor is 1, the entry is empty and nothing moves.
// Control and payload state is updated only at an edge that accepts an input.
// ----------------------------------------------------------------------------
module keypad_floor_stepper_seven_segment (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kfss_pkg::kfss_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kfss_pkg::kfss_out_t out_data_o
);
  import kfss_pkg::*;

  logic       accept;
  logic       out_valid_q, out_valid_d;
  kfss_out_t  out_q, out_d;
  kfss_view_t view;
  seg_vec_t   seg;

  // The result register can take a new result when it is empty or when its
  // present result leaves in the same cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Entry, target and travel state; view is the state after this item.
  kfss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .view_o   (view)
  );

  // The floor is kept in BCD as well, so the display needs no divider.
  kfss_seg_dec u_seg_dec (
    .bcd_i (view.floor_bcd),
    .seg_o (seg)
  );

  always_comb begin
    out_d.floor_now     = view.floor;
    out_d.entry_value   = view.entry;
    out_d.seg_ones      = seg[0];
    out_d.seg_tens      = seg[1];
    out_d.seg_hundreds  = seg[2];
    out_d.seg_thousands = seg[3];
    out_d.moving        = view.moving;
    out_d.going_up      = view.going_up;
    out_d.arrived       = view.arrived;
    out_d.rejected      = view.rejected;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The payload register loads only on an accepted transaction, so a
  // stalled result holds still.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/sv/keypad_floor_stepper_seven_segment_tb.sv
// ----------------------------------------------------------------------------
// keypad_floor_stepper_seven_segment_tb: self-checking bench of the stepper
// Feeds key and tick transactions through the valid/stall input channel and
// predicts every readout transaction with an independent model of the floor
// selector. Both channels idle and stall in random bursts. One long receiver
// hold-off backs the block up into its input. Readouts are checked field by
// field in order of arrival.
// ----------------------------------------------------------------------------
module keypad_floor_stepper_seven_segment_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kfss_pkg::*;

  // After this many idle cycles on both channels the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Once fewer than this many transactions remain queued, nobody idles.
  localparam int TAIL_ITEMS     = 64;
  // The long receiver hold-off starts after this many accepted inputs.
  localparam int HOLD_AFTER     = 120;
  localparam int HOLD_CYCLES    = 60;
  // The block answers in the cycle after it accepts.
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 450;

  // Seven-segment patterns of the decimal digits, A in bit 0, DP always off.
  localparam logic [0:9][7:0] SEG_PATTERN = {
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h67
  };

  // Everything the elevator remembers between transactions.
  typedef struct packed {
    floor_t             floor;
    floor_t             target;
    floor_t             entry;
    logic [DigitsW-1:0] digits;
    logic               travel;
    logic               up;
  } car_state_t;

  localparam car_state_t CAR_RESET = '{
    floor: FLOOR_RESET, target: '0, entry: '0, digits: '0, travel: 1'b0, up: 1'b0
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  kfss_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  kfss_out_t out_data;

  // Transactions waiting to be offered, and readouts waiting to be seen.
  kfss_in_t   queued_events[$];
  kfss_out_t  expected_readouts[$];

  // The stimulus builder runs its own copy of the model so that it always
  // knows the floor, the entry and whether the car is travelling.
  car_state_t gen_st       = CAR_RESET;
  car_state_t model_st     = CAR_RESET;
  int         counted      = 0;
  int         mismatches   = 0;
  int         inputs_taken = 0;
  int         idle_cycles  = 0;

  // Idling bookkeeping of the two sides.
  int drv_gap   = 0;
  int drv_calm  = 0;
  int rcv_stall = 0;
  int rcv_calm  = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  keypad_floor_stepper_seven_segment uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Applies one key or tick to the car and returns the readout that follows.
  // Digits build the entry up to four characters, the clear key empties it
  // and the go key turns it into the target. A target equal to the current
  // floor is refused; any other one starts travel, during which every key is
  // ignored and each tick moves one floor closer.
  function automatic kfss_out_t elevator_next(input car_state_t cur, input kfss_in_t ev,
                                              output car_state_t nxt);
    kfss_out_t   rd;
    int unsigned fl;
    nxt = cur;
    rd  = '0;
    if (ev.mode == MODE_KEY) begin
      if (!cur.travel) begin
        if (ev.key_code >= KEY_ZERO && ev.key_code <= KEY_NINE) begin
          if (cur.digits < DIGIT_LIMIT) begin
            nxt.entry  = floor_t'(cur.entry * 10 + (ev.key_code - KEY_ZERO));
            nxt.digits = cur.digits + 1'b1;
          end
        end else if (ev.key_code == KEY_CLEAR) begin
          nxt.entry  = '0;
          nxt.digits = '0;
        end else if (ev.key_code == KEY_GO) begin
          nxt.target = cur.entry;
          nxt.entry  = '0;
          nxt.digits = '0;
          if (cur.entry == cur.floor) begin
            rd.rejected = 1'b1;
          end else begin
            nxt.travel = 1'b1;
            nxt.up     = cur.entry > cur.floor;
          end
        end
      end
    end else if (cur.travel) begin
      if (cur.floor < cur.target) begin
        nxt.floor = cur.floor + 1'b1;
      end else if (cur.floor > cur.target) begin
        nxt.floor = cur.floor - 1'b1;
      end
      if (nxt.floor == cur.target) begin
        nxt.travel  = 1'b0;
        rd.arrived  = 1'b1;
      end
    end
    fl               = 32'(nxt.floor);
    rd.floor_now     = nxt.floor;
    rd.entry_value   = nxt.entry;
    rd.seg_ones      = SEG_PATTERN[fl % 10];
    rd.seg_tens      = SEG_PATTERN[(fl / 10) % 10];
    rd.seg_hundreds  = SEG_PATTERN[(fl / 100) % 10];
    rd.seg_thousands = SEG_PATTERN[(fl / 1000) % 10];
    rd.moving        = nxt.travel;
    rd.going_up      = nxt.travel && nxt.up;
    return rd;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------

  // Queues one transaction and advances the builder's copy of the car. Every
  // queued transaction counts toward the item budget.
  task automatic stage_event(input logic mode, input logic [7:0] key);
    kfss_in_t   ev;
    car_state_t nxt;
    ev.mode     = mode;
    ev.key_code = key;
    counted++;
    queued_events.push_back(ev);
    void'(elevator_next(gen_st, ev, nxt));
    gen_st = nxt;
  endtask

  task automatic stage_key(input logic [7:0] key);
    stage_event(MODE_KEY, key);
  endtask

  // The key code of a tick carries no meaning, so it is random noise.
  task automatic stage_tick();
    stage_event(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // A go key is only let through when the trip it starts stays short; a far
  // target would cost thousands of ticks. Otherwise the entry gets cleared.
  function automatic logic [7:0] safe_go();
    int d;
    d = int'(gen_st.entry) - int'(gen_st.floor);
    return (d > 40 || d < -40) ? KEY_CLEAR : KEY_GO;
  endfunction

  function automatic logic [7:0] stray_key();
    logic [7:0] k;
    k = 8'($urandom_range(0, 255));
    return (k == KEY_GO) ? safe_go() : k;
  endfunction

  // A complete request: finish any travel, clear, type the floor, press go
  // and tick until arrival, with stray keys pressed during the ride. Padding
  // types four digits with leading zeros, and extra digits past the fourth
  // must be dropped by the block.
  task automatic journey(input int t, input bit pad, input bit extra);
    int n;
    while (gen_st.travel) stage_tick();
    stage_key(KEY_CLEAR);
    if (pad) n = 4;
    else if (t >= 1000) n = 4;
    else if (t >= 100) n = 3;
    else if (t >= 10) n = 2;
    else if (t > 0) n = 1;
    else n = $urandom_range(0, 1);  // floor 0 also by an empty entry
    for (int i = n - 1; i >= 0; i--) begin
      stage_key(KEY_ZERO + 8'((t / (10 ** i)) % 10));
    end
    if (extra && n == 4) begin
      repeat ($urandom_range(1, 2)) stage_key(KEY_ZERO + 8'($urandom_range(0, 9)));
    end
    stage_key(KEY_GO);
    while (gen_st.travel) begin
      if ($urandom_range(0, 5) == 0) stage_key(stray_key());
      else stage_tick();
    end
    repeat ($urandom_range(0, 1)) stage_tick();
  endtask

  initial begin : build_stimulus
    int  t;

    // Directed opening. An idle tick and unknown keys change nothing, go on
    // the empty entry heads for floor 0, a digit during the ride is ignored.
    stage_tick();
    stage_key(8'h00);
    stage_key(8'hFF);
    stage_key(KEY_GO);
    stage_key(KEY_ZERO + 8'd5);
    stage_tick();
    // Now at floor 0, so go on an empty entry names the current floor.
    stage_key(KEY_GO);
    // Leading zero counts as a digit, so the fifth digit is dropped.
    stage_key(KEY_ZERO);
    stage_key(KEY_ZERO + 8'd1);
    stage_key(KEY_ZERO + 8'd2);
    stage_key(KEY_ZERO + 8'd3);
    stage_key(KEY_ZERO + 8'd4);
    stage_key(KEY_CLEAR);
    // Largest entry, then the codes right beside the digit range.
    repeat (4) stage_key(KEY_NINE);
    stage_key(KEY_ZERO - 8'd1);
    stage_key(KEY_NINE + 8'd1);
    stage_key(KEY_CLEAR);
    // A short ride up; the trailing tick carries the go code and must not
    // act as a key.
    stage_key(KEY_ZERO + 8'd2);
    stage_key(KEY_GO);
    stage_tick();
    stage_tick();
    stage_event(MODE_TICK, KEY_GO);

    while (counted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 5) == 0) begin
            t = int'(gen_st.floor);
          end else begin
            t = int'(gen_st.floor) + int'($urandom_range(0, 24)) - 12;
          end
          if (t < 0) t = 0;
          if (t > 9999) t = 9999;
          journey(t, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
        end
        7, 8: begin
          // Broken sequences: half-typed entries, stray clears and ticks.
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 4))
              0, 1: stage_key(KEY_ZERO + 8'($urandom_range(0, 9)));
              2: stage_key(KEY_CLEAR);
              3: stage_key(safe_go());
              default: stage_tick();
            endcase
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) stage_event(1'($urandom_range(0, 1)), stray_key());
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input driver: offers queued transactions, holding each one until the
  // block takes it, with random gaps between them.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : drive
    kfss_in_t next_item;
    logic     offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      drv_gap  <= 0;
      drv_calm <= 0;
    end else if (!in_valid || !in_stall) begin
      offer     = 1'b0;
      next_item = in_data;
      if (queued_events.size() == 0) begin
        offer = 1'b0;
      end else if (queued_events.size() < TAIL_ITEMS || hold_left > 0) begin
        // No gaps at the end, and none while the receiver is holding off so
        // that the block really fills up.
        offer = 1'b1;
      end else if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
      end else if (drv_calm > 0) begin
        offer = 1'b1;
        drv_calm <= drv_calm - 1;
      end else if ($urandom_range(0, 15) == 0) begin
        drv_gap <= $urandom_range(1, 18) - 1;
      end else begin
        offer = 1'b1;
        if ($urandom_range(0, 31) == 0) drv_calm <= $urandom_range(20, 80);
      end
      if (offer) next_item = queued_events.pop_front();
      in_valid <= offer;
      in_data  <= next_item;
    end
  end

  // --------------------------------------------------------------------------
  // Output receiver: stalls in random bursts, once for a long stretch.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : receive
    if (!rst_n) begin
      out_stall <= 1'b0;
      rcv_stall <= 0;
      rcv_calm  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && inputs_taken >= HOLD_AFTER) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (queued_events.size() < TAIL_ITEMS) begin
      out_stall <= 1'b0;
    end else if (rcv_stall > 0) begin
      out_stall <= 1'b1;
      rcv_stall <= rcv_stall - 1;
    end else if (rcv_calm > 0) begin
      out_stall <= 1'b0;
      rcv_calm  <= rcv_calm - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      rcv_stall <= $urandom_range(1, 18) - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 31) == 0) rcv_calm <= $urandom_range(20, 80);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted input transaction and checks every
  // accepted readout against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin : watch
    kfss_out_t  want;
    car_state_t nxt;
    if (!rst_n) begin
      model_st = CAR_RESET;
    end else begin
      // Prediction goes in first so a same-edge readout always finds it.
      if (in_valid && !in_stall) begin
        expected_readouts.push_back(elevator_next(model_st, in_data, nxt));
        model_st = nxt;
        inputs_taken <= inputs_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_readouts.size() == 0) begin
          $error("readout transaction with no prediction waiting");
          mismatches++;
        end else begin
          want = expected_readouts.pop_front();
          check_field("floor_now", 32'(want.floor_now), 32'(out_data.floor_now));
          check_field("entry_value", 32'(want.entry_value), 32'(out_data.entry_value));
          check_field("seg_ones", 32'(want.seg_ones), 32'(out_data.seg_ones));
          check_field("seg_tens", 32'(want.seg_tens), 32'(out_data.seg_tens));
          check_field("seg_hundreds", 32'(want.seg_hundreds),
                      32'(out_data.seg_hundreds));
          check_field("seg_thousands", 32'(want.seg_thousands),
                      32'(out_data.seg_thousands));
          check_field("moving", 32'(want.moving), 32'(out_data.moving));
          check_field("going_up", 32'(want.going_up), 32'(out_data.going_up));
          check_field("arrived", 32'(want.arrived), 32'(out_data.arrived));
          check_field("rejected", 32'(want.rejected), 32'(out_data.rejected));
        end
      end
    end
  end

  // Watchdog: a run where neither channel moves for too long is hung, which
  // also catches predictions that never get their readout.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset once, then wait until every transaction is in and every readout
  // has been checked, let the block settle and report.
  initial begin : finale
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (queued_events.size() != 0 || in_valid || expected_readouts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> keypad_floor_stepper_seven_segment.f
rtl/kfss_pkg.sv
rtl/kfss_ctrl.sv
rtl/kfss_seg_dec.sv
rtl/keypad_floor_stepper_seven_segment.sv
tb/sv/keypad_floor_stepper_seven_segment_tb.sv
